// ===== sv/wpi_pkg.sv =====
// ----------------------------------------------------------------------------
// wpi_pkg: shared types and constants of the pedestal integrator
// Field widths, register codes, the front-to-back queue entry and config bundle.
// ----------------------------------------------------------------------------
package wpi_pkg;

	localparam int MAX_SAMPLES = 2048;
	localparam int ADC_BITS    = 14;

	localparam int ADC_W   = 14;
	localparam int CH_W    = 9;
	localparam int IDX_W   = 12;
	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 2;
	localparam int PED_W   = 25;
	localparam int SUM_W   = 26;
	localparam int OSUM_W  = 25;
	localparam int SQR_W   = 2 * ADC_W;
	localparam int SQ_W    = 40;
	localparam int OSQ_W   = 39;
	localparam int INT_W   = 38;
	localparam int PROD_W  = CFG_W + SUM_W;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((1 << ADC_BITS) - 1);
	localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_SAMPLES);

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_PED_SAMPLES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_INDEX  = 2'd2;

	localparam logic [CFG_W-1:0] PED_SAMPLES_RST  = 12'd40;
	localparam logic [CFG_W-1:0] CALIB_WINDOW_RST = 12'd20;
	localparam logic [CFG_W-1:0] SPLIT_INDEX_RST  = 12'd800;

	// result kinds
	localparam logic KIND_CALIB   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] ped_samples;
		logic [CFG_W-1:0] calib_window;
		logic [CFG_W-1:0] split_index;
	} wpi_cfg_t;

	// snapshot of the running values after one sample, plus what to emit
	typedef struct packed {
		logic              calib;
		logic              last;
		logic [CH_W-1:0]   channel;
		logic [ADC_W-1:0]  max_adc;
		logic [PED_W-1:0]  ped_sum;
		logic [SUM_W-1:0]  total;
		logic [SQ_W-1:0]   squares;
		logic [IDX_W-1:0]  count;
		logic [SUM_W-1:0]  ap_sum;
		logic [IDX_W-1:0]  ap_count;
		logic [SUM_W-1:0]  post_sum;
		logic [IDX_W-1:0]  post_count;
		logic [SUM_W-1:0]  cal_sum;
		logic [IDX_W-1:0]  cal_terms;
	} wpi_entry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} wpi_qstat_t;

endpackage

// ===== sv/wpi_front.sv =====
// ----------------------------------------------------------------------------
// wpi_front: sample intake and waveform accumulators
// Registers the sample and its square, updates the running sums and decides
// which result words the sample causes; those are pushed to the queue.
// ----------------------------------------------------------------------------
module wpi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wpi_pkg::wpi_cfg_t           cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wpi_pkg::ADC_W-1:0]   adc_sample,
	input  logic [wpi_pkg::CH_W-1:0]    channel,
	input  logic                        last_sample,
	input  wpi_pkg::wpi_qstat_t         qstat,
	output logic                        push,
	output wpi_pkg::wpi_entry_t         push_entry
);

	localparam int QW = wpi_pkg::QCNT_W + 1;

	// intake stage
	logic                          valid_s1;
	logic [wpi_pkg::ADC_W-1:0]     x_s1;
	logic [wpi_pkg::SQR_W-1:0]     xsq_s1;
	logic [wpi_pkg::CH_W-1:0]      ch_s1;
	logic                          last_s1;

	// waveform state
	logic [wpi_pkg::IDX_W-1:0]     index_q;
	logic [wpi_pkg::PED_W-1:0]     ped_q;
	logic [wpi_pkg::ADC_W-1:0]     max_q;
	logic [wpi_pkg::SUM_W-1:0]     sum_q;
	logic [wpi_pkg::SQ_W-1:0]      sq_q;
	logic [wpi_pkg::SUM_W-1:0]     ap_sum_q;
	logic [wpi_pkg::IDX_W-1:0]     ap_cnt_q;
	logic [wpi_pkg::SUM_W-1:0]     post_sum_q;
	logic [wpi_pkg::IDX_W-1:0]     post_cnt_q;
	logic [wpi_pkg::SUM_W-1:0]     cal_sum_q;
	logic [wpi_pkg::IDX_W-1:0]     cal_terms_q;
	logic [wpi_pkg::IDX_W-1:0]     peak_q;

	logic                          accept;
	logic [QW-1:0]                 occ;
	logic [wpi_pkg::ADC_W-1:0]     x_in;

	logic                          live, pre_ped, post_ped, in_cal, post_split;
	logic                          restart, in_win, hit;
	logic [wpi_pkg::IDX_W-1:0]     peak_gap;
	logic [wpi_pkg::SUM_W-1:0]     xs;
	logic [wpi_pkg::SUM_W-1:0]     cal_base_sum;
	logic [wpi_pkg::IDX_W-1:0]     cal_base_terms;

	logic [wpi_pkg::IDX_W-1:0]     nx_index;
	logic [wpi_pkg::PED_W-1:0]     nx_ped;
	logic [wpi_pkg::ADC_W-1:0]     nx_max;
	logic [wpi_pkg::SUM_W-1:0]     nx_sum;
	logic [wpi_pkg::SQ_W-1:0]      nx_sq;
	logic [wpi_pkg::SUM_W-1:0]     nx_ap_sum;
	logic [wpi_pkg::IDX_W-1:0]     nx_ap_cnt;
	logic [wpi_pkg::SUM_W-1:0]     nx_post_sum;
	logic [wpi_pkg::IDX_W-1:0]     nx_post_cnt;
	logic [wpi_pkg::SUM_W-1:0]     nx_cal_sum;
	logic [wpi_pkg::IDX_W-1:0]     nx_cal_terms;
	logic [wpi_pkg::IDX_W-1:0]     nx_peak;

	// room for the word in flight plus the one being taken now
	assign occ      = {1'b0, qstat.count} + QW'(valid_s1);
	assign in_ready = occ < QW'(wpi_pkg::QDEPTH);
	assign accept   = in_valid && in_ready;
	assign x_in     = adc_sample & wpi_pkg::ADC_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= x_in;
			xsq_s1  <= x_in * x_in;
			ch_s1   <= channel;
			last_s1 <= last_sample;
		end
	end

	// classify the sample by its index
	always_comb begin
		live       = index_q < wpi_pkg::IDX_LIMIT;
		pre_ped    = index_q < cfg.ped_samples;
		post_ped   = index_q > cfg.ped_samples;
		in_cal     = post_ped && (index_q < cfg.split_index);
		post_split = index_q > cfg.split_index;
		xs         = wpi_pkg::SUM_W'(x_s1);

		// equal to the updated maximum means no smaller than the old one
		restart        = in_cal && (x_s1 >= max_q);
		peak_gap       = restart ? '0 : (index_q - peak_q);
		in_win         = in_cal && (peak_gap < cfg.calib_window);
		hit            = in_cal && (peak_gap == cfg.calib_window);
		cal_base_sum   = restart ? xs : cal_sum_q;
		cal_base_terms = restart ? wpi_pkg::IDX_W'(1) : cal_terms_q;

		nx_index     = index_q;
		nx_ped       = ped_q;
		nx_max       = max_q;
		nx_sum       = sum_q;
		nx_sq        = sq_q;
		nx_ap_sum    = ap_sum_q;
		nx_ap_cnt    = ap_cnt_q;
		nx_post_sum  = post_sum_q;
		nx_post_cnt  = post_cnt_q;
		nx_cal_sum   = cal_sum_q;
		nx_cal_terms = cal_terms_q;
		nx_peak      = peak_q;

		if (live) begin
			nx_index = index_q + 1'b1;
			if (pre_ped) nx_ped = ped_q + wpi_pkg::PED_W'(x_s1);
			if (x_s1 > max_q) nx_max = x_s1;
			nx_sum = sum_q + xs;
			nx_sq  = sq_q + wpi_pkg::SQ_W'(xsq_s1);
			if (post_ped) begin
				nx_ap_sum = ap_sum_q + xs;
				nx_ap_cnt = ap_cnt_q + 1'b1;
			end
			if (in_cal) begin
				nx_cal_sum   = in_win ? cal_base_sum + xs : cal_base_sum;
				nx_cal_terms = in_win ? cal_base_terms + 1'b1 : cal_base_terms;
				if (restart) nx_peak = index_q;
			end
			if (post_split) begin
				nx_post_sum = post_sum_q + xs;
				nx_post_cnt = post_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		push_entry.calib      = live && hit;
		push_entry.last       = last_s1;
		push_entry.channel    = ch_s1;
		push_entry.max_adc    = nx_max;
		push_entry.ped_sum    = nx_ped;
		push_entry.total      = nx_sum;
		push_entry.squares    = nx_sq;
		push_entry.count      = nx_index;
		push_entry.ap_sum     = nx_ap_sum;
		push_entry.ap_count   = nx_ap_cnt;
		push_entry.post_sum   = nx_post_sum;
		push_entry.post_count = nx_post_cnt;
		push_entry.cal_sum    = nx_cal_sum;
		push_entry.cal_terms  = nx_cal_terms;
		push = valid_s1 && (push_entry.calib || last_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q     <= '0;
			ped_q       <= '0;
			max_q       <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			ap_sum_q    <= '0;
			ap_cnt_q    <= '0;
			post_sum_q  <= '0;
			post_cnt_q  <= '0;
			cal_sum_q   <= '0;
			cal_terms_q <= '0;
			peak_q      <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				index_q     <= '0;
				ped_q       <= '0;
				max_q       <= '0;
				sum_q       <= '0;
				sq_q        <= '0;
				ap_sum_q    <= '0;
				ap_cnt_q    <= '0;
				post_sum_q  <= '0;
				post_cnt_q  <= '0;
				cal_sum_q   <= '0;
				cal_terms_q <= '0;
				peak_q      <= '0;
			end else begin
				index_q     <= nx_index;
				ped_q       <= nx_ped;
				max_q       <= nx_max;
				sum_q       <= nx_sum;
				sq_q        <= nx_sq;
				ap_sum_q    <= nx_ap_sum;
				ap_cnt_q    <= nx_ap_cnt;
				post_sum_q  <= nx_post_sum;
				post_cnt_q  <= nx_post_cnt;
				cal_sum_q   <= nx_cal_sum;
				cal_terms_q <= nx_cal_terms;
				peak_q      <= nx_peak;
			end
		end
	end

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		index_q <= wpi_pkg::IDX_LIMIT)
		else $error("sample index ran past the waveform limit");

endmodule

// ===== sv/wpi_queue.sv =====
// ----------------------------------------------------------------------------
// wpi_queue: short FIFO between the accumulators and the result stage
// Holds accumulator snapshots of samples that produce result words.
// ----------------------------------------------------------------------------
module wpi_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wpi_pkg::wpi_entry_t  push_entry,
	input  logic                 pop,
	output wpi_pkg::wpi_entry_t  head,
	output wpi_pkg::wpi_qstat_t  qstat
);

	wpi_pkg::wpi_entry_t             mem_q [wpi_pkg::QDEPTH];
	logic [wpi_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [wpi_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [wpi_pkg::QCNT_W-1:0]      count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != wpi_pkg::QCNT_W'(wpi_pkg::QDEPTH)) || pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

// ===== sv/wpi_back.sv =====
// ----------------------------------------------------------------------------
// wpi_back: scaled integrals and result output register
// Multiplies out the three pedestal-subtracted integrals, saturates them and
// presents one or two result words per queue entry.
// ----------------------------------------------------------------------------
module wpi_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [wpi_pkg::CFG_W-1:0]          ped_samples,
	input  wpi_pkg::wpi_qstat_t                qstat,
	input  wpi_pkg::wpi_entry_t                head,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               result_kind,
	output logic                               is_last,
	output logic [wpi_pkg::CH_W-1:0]           out_channel,
	output logic [wpi_pkg::ADC_W-1:0]          max_adc,
	output logic [wpi_pkg::PED_W-1:0]          pedestal_sum,
	output logic [wpi_pkg::OSUM_W-1:0]         total_sum,
	output logic [wpi_pkg::OSQ_W-1:0]          sum_squares,
	output logic [wpi_pkg::IDX_W-1:0]          sample_count,
	output logic signed [wpi_pkg::INT_W-1:0]   pedsub_integral_scaled,
	output logic signed [wpi_pkg::INT_W-1:0]   post_integral_scaled,
	output logic signed [wpi_pkg::INT_W-1:0]   calib_integral_scaled
);

	localparam logic [wpi_pkg::INT_W-1:0] INT_MAX = {1'b0, {(wpi_pkg::INT_W-1){1'b1}}};
	localparam logic [wpi_pkg::INT_W-1:0] INT_MIN = {1'b1, {(wpi_pkg::INT_W-1){1'b0}}};

	// a - b, clipped to the signed integral range
	function automatic logic [wpi_pkg::INT_W-1:0] sat_diff(
		input logic [wpi_pkg::PROD_W-1:0] a,
		input logic [wpi_pkg::PROD_W-1:0] b
	);
		logic [wpi_pkg::PROD_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[wpi_pkg::PROD_W] != d[wpi_pkg::INT_W-1])
			sat_diff = d[wpi_pkg::PROD_W] ? INT_MIN : INT_MAX;
		else
			sat_diff = d[wpi_pkg::INT_W-1:0];
	endfunction

	// multiply stage
	logic                          valid_b1;
	wpi_pkg::wpi_entry_t           ent_b1;
	logic [wpi_pkg::PROD_W-1:0]    ap_raw_b1, ap_ped_b1;
	logic [wpi_pkg::PROD_W-1:0]    post_raw_b1, post_ped_b1;
	logic [wpi_pkg::PROD_W-1:0]    cal_raw_b1, cal_ped_b1;

	// output stage
	logic                          valid_b2;
	logic                          calib_b2;
	logic                          last_b2;
	logic [wpi_pkg::CH_W-1:0]      ch_b2;
	logic [wpi_pkg::ADC_W-1:0]     max_b2;
	logic [wpi_pkg::PED_W-1:0]     ped_b2;
	logic [wpi_pkg::OSUM_W-1:0]    sum_b2;
	logic [wpi_pkg::OSQ_W-1:0]     sq_b2;
	logic [wpi_pkg::IDX_W-1:0]     cnt_b2;
	logic [wpi_pkg::INT_W-1:0]     ap_int_b2, post_int_b2, cal_int_b2;

	logic final_word, b2_free, b1_adv, split_take;

	// an entry with both a calibration and a summary shows two words
	assign final_word = !(calib_b2 && last_b2);
	assign b2_free    = !valid_b2 || (out_ready && final_word);
	assign b1_adv     = valid_b1 && b2_free;
	assign pop        = !qstat.empty && (!valid_b1 || b2_free);
	assign split_take = valid_b2 && out_ready && !final_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
			calib_b2 <= 1'b0;
			last_b2  <= 1'b0;
		end else begin
			if (pop)
				valid_b1 <= 1'b1;
			else if (b1_adv)
				valid_b1 <= 1'b0;

			if (b1_adv) begin
				valid_b2 <= 1'b1;
				calib_b2 <= ent_b1.calib;
				last_b2  <= ent_b1.last;
			end else if (valid_b2 && out_ready && final_word) begin
				valid_b2 <= 1'b0;
			end else if (split_take) begin
				calib_b2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_b1      <= head;
			ap_raw_b1   <= ped_samples * head.ap_sum;
			ap_ped_b1   <= head.ped_sum * head.ap_count;
			post_raw_b1 <= ped_samples * head.post_sum;
			post_ped_b1 <= head.ped_sum * head.post_count;
			cal_raw_b1  <= ped_samples * head.cal_sum;
			cal_ped_b1  <= head.ped_sum * head.cal_terms;
		end
	end

	always_ff @(posedge clk) begin
		if (b1_adv) begin
			ch_b2       <= ent_b1.channel;
			max_b2      <= ent_b1.max_adc;
			ped_b2      <= ent_b1.ped_sum;
			sum_b2      <= ent_b1.total[wpi_pkg::OSUM_W-1:0];
			sq_b2       <= ent_b1.squares[wpi_pkg::OSQ_W-1:0];
			cnt_b2      <= ent_b1.count;
			ap_int_b2   <= sat_diff(ap_raw_b1, ap_ped_b1);
			post_int_b2 <= sat_diff(post_raw_b1, post_ped_b1);
			cal_int_b2  <= sat_diff(cal_raw_b1, cal_ped_b1);
		end
	end

	assign out_valid              = valid_b2;
	assign result_kind            = calib_b2 ? wpi_pkg::KIND_CALIB : wpi_pkg::KIND_SUMMARY;
	assign is_last                = calib_b2 ? !last_b2 : 1'b1;
	assign out_channel            = ch_b2;
	assign max_adc                = max_b2;
	assign pedestal_sum           = ped_b2;
	assign total_sum              = sum_b2;
	assign sum_squares            = sq_b2;
	assign sample_count           = cnt_b2;
	assign pedsub_integral_scaled = ap_int_b2;
	assign post_integral_scaled   = post_int_b2;
	assign calib_integral_scaled  = cal_int_b2;

	a_summary_follows: assert property (@(posedge clk) disable iff (!arst_n)
		split_take |=> (valid_b2 && !calib_b2 && last_b2))
		else $error("summary word did not follow calibration word");

endmodule

// ===== sv/waveform_pedestal_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// waveform_pedestal_integrator_unit: pedestal-subtracted pulse integrator
// Per-waveform sums, maximum, pedestal and scaled integrals of an ADC stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one ADC word per cycle with its channel
// and a last_sample mark on the final word of the waveform. Words keep
// flowing at one per clock while in_ready is high; in_ready drops only when
// the four-entry result queue is nearly full.
// Output channel (out_valid/out_ready): a calibration word (kind 0) when the
// window after the latest peak closes, and a summary word (kind 1) after the
// last sample. A sample that causes both shows two words, calibration first.
// A result word passes the intake register, the accumulator update and queue
// write, the multiply stage and the saturation into the output register.
// Throughput: one sample per cycle while in_ready is high, set by the
// accumulator loop; the output side sustains one word per cycle while
// out_ready is high. Stalls: when out_ready is low the output register holds,
// the queue absorbs up to four pending entries, then in_ready goes low.
// Reset (arst_n low) clears all waveform state and the queue and loads the
// register defaults: ped_samples 40, calib_window 20, split_index 800.
// The user writes configuration (cfg_write/cfg_index/cfg_data) only while
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module waveform_pedestal_integrator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_write,
	input  logic [wpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wpi_pkg::CFG_W-1:0]          cfg_data,
	// sample stream
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [wpi_pkg::ADC_W-1:0]          adc_sample,
	input  logic [wpi_pkg::CH_W-1:0]           channel,
	input  logic                               last_sample,
	// result stream
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               result_kind,
	output logic                               is_last,
	output logic [wpi_pkg::CH_W-1:0]           out_channel,
	output logic [wpi_pkg::ADC_W-1:0]          max_adc,
	output logic [wpi_pkg::PED_W-1:0]          pedestal_sum,
	output logic [wpi_pkg::OSUM_W-1:0]         total_sum,
	output logic [wpi_pkg::OSQ_W-1:0]          sum_squares,
	output logic [wpi_pkg::IDX_W-1:0]          sample_count,
	output logic signed [wpi_pkg::INT_W-1:0]   pedsub_integral_scaled,
	output logic signed [wpi_pkg::INT_W-1:0]   post_integral_scaled,
	output logic signed [wpi_pkg::INT_W-1:0]   calib_integral_scaled
);

	wpi_pkg::wpi_cfg_t    cfg_q;
	wpi_pkg::wpi_qstat_t  qstat;
	wpi_pkg::wpi_entry_t  push_entry;
	wpi_pkg::wpi_entry_t  head;
	logic                 push;
	logic                 pop;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ped_samples  <= wpi_pkg::PED_SAMPLES_RST;
			cfg_q.calib_window <= wpi_pkg::CALIB_WINDOW_RST;
			cfg_q.split_index  <= wpi_pkg::SPLIT_INDEX_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				wpi_pkg::CFG_PED_SAMPLES:  cfg_q.ped_samples  <= cfg_data;
				wpi_pkg::CFG_CALIB_WINDOW: cfg_q.calib_window <= cfg_data;
				wpi_pkg::CFG_SPLIT_INDEX:  cfg_q.split_index  <= cfg_data;
				default:                   cfg_q              <= cfg_q;
			endcase
		end
	end

	// front: intake, accumulators, result classification
	wpi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.adc_sample  (adc_sample),
		.channel     (channel),
		.last_sample (last_sample),
		.qstat       (qstat),
		.push        (push),
		.push_entry  (push_entry)
	);

	// snapshots waiting for the result stage
	wpi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// back: scaling multiplies, saturation, output register
	wpi_back u_back (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.ped_samples            (cfg_q.ped_samples),
		.qstat                  (qstat),
		.head                   (head),
		.pop                    (pop),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.result_kind            (result_kind),
		.is_last                (is_last),
		.out_channel            (out_channel),
		.max_adc                (max_adc),
		.pedestal_sum           (pedestal_sum),
		.total_sum              (total_sum),
		.sum_squares            (sum_squares),
		.sample_count           (sample_count),
		.pedsub_integral_scaled (pedsub_integral_scaled),
		.post_integral_scaled   (post_integral_scaled),
		.calib_integral_scaled  (calib_integral_scaled)
	);

endmodule

// ===== dv/waveform_pedestal_integrator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waveform_pedestal_integrator_unit_test: self-checking bench for the integrator
// Streams ADC waveforms through the unit under random back-pressure. A local
// copy of the per-waveform accumulators predicts every calibration and summary
// word, and each accepted output word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module waveform_pedestal_integrator_unit_test;

	// run shape
	localparam int RANDOM_ITEMS = 880;
	localparam int IDLE_GAP     = 10;       // outlasts the result path, covers a silent sample
	localparam int LONG_HOLD    = 400;      // receiver hold-off, cycles
	localparam int CYCLE_LIMIT  = 800000;

	typedef enum {SHAPE_PULSE, SHAPE_PLATEAU, SHAPE_NOISE} wave_shape_t;

	// one input word
	typedef struct {
		logic [wpi_pkg::ADC_W-1:0] adc;
		logic [wpi_pkg::CH_W-1:0]  ch;
		logic                      last;
	} sample_word_t;

	// one predicted output word
	typedef struct {
		logic                       kind;
		logic                       last;
		logic [wpi_pkg::CH_W-1:0]   ch;
		logic [wpi_pkg::ADC_W-1:0]  max_adc;
		logic [wpi_pkg::PED_W-1:0]  ped_sum;
		logic [wpi_pkg::OSUM_W-1:0] total;
		logic [wpi_pkg::OSQ_W-1:0]  squares;
		logic [wpi_pkg::IDX_W-1:0]  count;
		logic [wpi_pkg::INT_W-1:0]  pedsub;
		logic [wpi_pkg::INT_W-1:0]  post;
		logic [wpi_pkg::INT_W-1:0]  calib;
	} pulse_result_t;

	// clock, reset and DUT ports; every input starts at a known value
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [wpi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [wpi_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [wpi_pkg::ADC_W-1:0] adc_sample = '0;
	logic [wpi_pkg::CH_W-1:0] channel = '0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic is_last;
	logic [wpi_pkg::CH_W-1:0] out_channel;
	logic [wpi_pkg::ADC_W-1:0] max_adc;
	logic [wpi_pkg::PED_W-1:0] pedestal_sum;
	logic [wpi_pkg::OSUM_W-1:0] total_sum;
	logic [wpi_pkg::OSQ_W-1:0] sum_squares;
	logic [wpi_pkg::IDX_W-1:0] sample_count;
	logic signed [wpi_pkg::INT_W-1:0] pedsub_integral_scaled;
	logic signed [wpi_pkg::INT_W-1:0] post_integral_scaled;
	logic signed [wpi_pkg::INT_W-1:0] calib_integral_scaled;

	waveform_pedestal_integrator_unit DUT (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_write              (cfg_write),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.adc_sample             (adc_sample),
		.channel                (channel),
		.last_sample            (last_sample),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.result_kind            (result_kind),
		.is_last                (is_last),
		.out_channel            (out_channel),
		.max_adc                (max_adc),
		.pedestal_sum           (pedestal_sum),
		.total_sum              (total_sum),
		.sum_squares            (sum_squares),
		.sample_count           (sample_count),
		.pedsub_integral_scaled (pedsub_integral_scaled),
		.post_integral_scaled   (post_integral_scaled),
		.calib_integral_scaled  (calib_integral_scaled)
	);

	// 4 ns period
	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor: shadow registers and per-waveform accumulators
	// ------------------------------------------------------------------------
	longint cfg_ped    = wpi_pkg::PED_SAMPLES_RST;
	longint cfg_window = wpi_pkg::CALIB_WINDOW_RST;
	longint cfg_split  = wpi_pkg::SPLIT_INDEX_RST;

	longint wave_index, ped_acc, max_acc, sum_acc, square_acc;
	longint ap_sum, ap_count, post_sum, post_count;
	longint cal_sum, cal_terms, peak_at;

	pulse_result_t expected_results[$];
	sample_word_t  pending_samples[$];

	int samples_queued = 0;   // pushed by the stimulus
	int samples_taken  = 0;   // accepted by the DUT
	int error_count    = 0;
	int cycle_count    = 0;
	int hold_req       = 0;   // bumped to ask the receiver for a long hold-off

	function automatic void clear_waveform();
		wave_index = 0; ped_acc = 0; max_acc = 0; sum_acc = 0; square_acc = 0;
		ap_sum = 0; ap_count = 0; post_sum = 0; post_count = 0;
		cal_sum = 0; cal_terms = 0; peak_at = 0;
	endfunction

	// ped_samples*raw - pedestal*terms, clamped to 38-bit signed
	function automatic logic [wpi_pkg::INT_W-1:0] scale_integral(longint raw, longint terms);
		longint v;
		v = cfg_ped * raw - ped_acc * terms;
		if (v > 64'sd137438953471) v = 64'sd137438953471;
		if (v < -64'sd137438953472) v = -64'sd137438953472;
		return v[wpi_pkg::INT_W-1:0];
	endfunction

	function automatic pulse_result_t snapshot(logic kind, logic last_flag,
			logic [wpi_pkg::CH_W-1:0] ch);
		pulse_result_t r;
		r.kind    = kind;
		r.last    = last_flag;
		r.ch      = ch;
		r.max_adc = max_acc[wpi_pkg::ADC_W-1:0];
		r.ped_sum = ped_acc[wpi_pkg::PED_W-1:0];
		r.total   = sum_acc[wpi_pkg::OSUM_W-1:0];
		r.squares = square_acc[wpi_pkg::OSQ_W-1:0];
		r.count   = wave_index[wpi_pkg::IDX_W-1:0];
		r.pedsub  = scale_integral(ap_sum, ap_count);
		r.post    = scale_integral(post_sum, post_count);
		r.calib   = scale_integral(cal_sum, cal_terms);
		return r;
	endfunction

	// advance the accumulators by one accepted word and queue what it causes
	function automatic void integrate_sample(sample_word_t w);
		longint x;
		longint i;
		bit     calib_due;
		x = longint'(w.adc) & ((64'sd1 << wpi_pkg::ADC_BITS) - 1);
		calib_due = 1'b0;
		// beyond the sample limit words are dropped, but the last mark still counts
		if (wave_index < wpi_pkg::MAX_SAMPLES) begin
			i = wave_index;
			if (i < cfg_ped) ped_acc += x;
			if (x > max_acc) max_acc = x;
			sum_acc += x;
			square_acc += x * x;
			if (i > cfg_ped) begin
				ap_sum += x;
				ap_count++;
			end
			if (i > cfg_ped && i < cfg_split) begin
				// a sample equal to the running max restarts the window; the
				// add below then counts the peak a second time
				if (x == max_acc) begin
					cal_sum = x;
					cal_terms = 1;
					peak_at = i;
				end
				if (i - peak_at < cfg_window) begin
					cal_sum += x;
					cal_terms++;
				end
				if (i - peak_at == cfg_window) calib_due = 1'b1;
			end
			if (i > cfg_split) begin
				post_sum += x;
				post_count++;
			end
			wave_index = i + 1;
		end
		if (calib_due)
			expected_results.push_back(snapshot(wpi_pkg::KIND_CALIB, !w.last, w.ch));
		if (w.last) begin
			expected_results.push_back(snapshot(wpi_pkg::KIND_SUMMARY, 1'b1, w.ch));
			clear_waveform();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// Driver: bursts of words with random gaps, fed from pending_samples
	// ------------------------------------------------------------------------
	sample_word_t cur_word;
	int burst_left = 8;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				integrate_sample(cur_word);
				samples_taken++;
			end
			// slot is free after this edge: idle for the gap or offer the next word
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					cur_word = pending_samples.pop_front();
					in_valid    <= 1'b1;
					adc_sample  <= cur_word.adc;
					channel     <= cur_word.ch;
					last_sample <= cur_word.last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: ready pattern in modes (always, coin flip, mostly stalled),
	// plus one long hold-off on request so the result queue fills up
	// ------------------------------------------------------------------------
	int hold_seen = 0;
	int hold_left = 0;
	int rx_mode   = 0;
	int mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(10, 200);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= ($urandom_range(0, 1) == 1);
					end
					default: begin
						out_ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every accepted output word against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		pulse_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("output word with nothing expected", 64'(result_kind),
					64'd0);
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 64'(result_kind), 64'(want.kind));
				check_field("is_last", 64'(is_last), 64'(want.last));
				check_field("out_channel", 64'(out_channel), 64'(want.ch));
				check_field("max_adc", 64'(max_adc), 64'(want.max_adc));
				check_field("pedestal_sum", 64'(pedestal_sum), 64'(want.ped_sum));
				check_field("total_sum", 64'(total_sum), 64'(want.total));
				check_field("sum_squares", 64'(sum_squares), 64'(want.squares));
				check_field("sample_count", 64'(sample_count), 64'(want.count));
				check_field("pedsub_integral_scaled", 64'($unsigned(pedsub_integral_scaled)),
					64'(want.pedsub));
				check_field("post_integral_scaled", 64'($unsigned(post_integral_scaled)),
					64'(want.post));
				check_field("calib_integral_scaled", 64'($unsigned(calib_integral_scaled)),
					64'(want.calib));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("waveform_pedestal_integrator_unit_test: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic queue_sample(int adc, int ch, bit last);
		sample_word_t w;
		w.adc  = wpi_pkg::ADC_W'(adc);
		w.ch   = wpi_pkg::CH_W'(ch);
		w.last = last;
		pending_samples.push_back(w);
		samples_queued++;
	endtask

	// all accepted, all results back, then let any silent word retire
	task automatic wait_idle();
		while (samples_taken != samples_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	// registers change only with the block idle
	task automatic set_config(int ped, int win, int split);
		logic [wpi_pkg::CFG_IDX_W-1:0] idx [3];
		int vals [3];
		wait_idle();
		idx[0] = wpi_pkg::CFG_PED_SAMPLES;  vals[0] = ped;
		idx[1] = wpi_pkg::CFG_CALIB_WINDOW; vals[1] = win;
		idx[2] = wpi_pkg::CFG_SPLIT_INDEX;  vals[2] = split;
		for (int k = 0; k < 3; k++) begin
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= wpi_pkg::CFG_W'(vals[k]);
			@(posedge clk);
			cfg_write <= 1'b0;
		end
		cfg_ped = ped;
		cfg_window = win;
		cfg_split = split;
	endtask

	// one waveform of the given length, last mark on its final word
	task automatic queue_waveform(int len, wave_shape_t shape);
		int ch, base, amp, noise, start, rise, fall, lo, hi, v, rel;
		ch    = $urandom_range(0, 511);
		base  = $urandom_range(0, 2000);
		amp   = $urandom_range(0, 14383);
		noise = $urandom_range(0, 15);
		start = $urandom_range(0, len);
		rise  = $urandom_range(1, 6);
		fall  = $urandom_range(1, 20);
		lo    = $urandom_range(0, 16383);
		hi    = $urandom_range(lo, 16383);
		for (int k = 0; k < len; k++) begin
			case (shape)
				SHAPE_PULSE: begin
					// baseline, then a triangular pulse
					v = base + $urandom_range(0, noise);
					if (k >= start) begin
						rel = k - start;
						if (rel < rise) v += amp * (rel + 1) / rise;
						else if (rel - rise + 1 < fall) v += amp - amp * (rel - rise + 1) / fall;
					end
					if (v > 16383) v = 16383;
				end
				SHAPE_PLATEAU: begin
					// two levels only, so the max repeats and restarts the window
					v = ($urandom_range(0, 2) == 0) ? lo : hi;
				end
				default: begin
					v = $urandom_range(0, 16383);
				end
			endcase
			queue_sample(v, ch, k == len - 1);
		end
	endtask

	initial begin : stimulus
		int random_base;
		int wave_count;
		bit hold_done;
		int pick;
		wave_shape_t shape;

		clear_waveform();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values: one- and two-word waveforms at the extremes
		queue_sample(0, 0, 1'b1);
		queue_sample(16383, 511, 1'b1);
		queue_sample(16383, 'h0AA, 1'b0);
		queue_sample(0, 'h0AA, 1'b1);

		// short pedestal and window: restarts on a new max and on an equal max,
		// window closing mid-waveform, then a window closing on the last word
		set_config(2, 3, 12);
		queue_sample(100, 'h155, 1'b0);
		queue_sample(102, 'h155, 1'b0);
		queue_sample(50, 'h155, 1'b0);
		queue_sample(200, 'h155, 1'b0);
		queue_sample(300, 'h155, 1'b0);
		queue_sample(300, 'h155, 1'b0);
		queue_sample(10, 'h155, 1'b0);
		queue_sample(10, 'h155, 1'b0);
		queue_sample(5, 'h155, 1'b0);
		queue_sample(16383, 'h155, 1'b1);
		queue_sample(7, 'h0F0, 1'b0);
		queue_sample(7, 'h0F0, 1'b0);
		queue_sample(0, 'h0F0, 1'b0);
		queue_sample(1, 'h0F0, 1'b1);

		// no pedestal: all scaled integrals zero; zero window emits on the peak
		set_config(0, 0, 2048);
		queue_sample(5, 'h1FF, 1'b0);
		queue_sample(9, 'h1FF, 1'b0);
		queue_sample(9, 'h1FF, 1'b0);
		queue_sample(3, 'h1FF, 1'b1);

		// random waveforms, mostly pulses, under changing settings
		random_base = samples_queued;
		wave_count = 0;
		hold_done = 1'b0;
		while (samples_queued - random_base < RANDOM_ITEMS) begin
			if (wave_count % 8 == 0) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) set_config(1, 0, 0);
				else if (pick == 1)
					set_config($urandom_range(0, 2048), $urandom_range(0, 2048),
						$urandom_range(0, 2048));
				else
					set_config($urandom_range(0, 12), $urandom_range(0, 16),
						$urandom_range(0, 70));
			end
			if (!hold_done && samples_queued - random_base > RANDOM_ITEMS / 2) begin
				// receiver holds off while short waveforms keep coming, so the
				// result queue fills and in_ready drops
				hold_req++;
				hold_done = 1'b1;
				repeat (40) queue_waveform($urandom_range(1, 2), SHAPE_NOISE);
			end
			pick = $urandom_range(0, 9);
			shape = (pick < 7) ? SHAPE_PULSE : (pick < 9) ? SHAPE_PLATEAU : SHAPE_NOISE;
			queue_waveform($urandom_range(1, 70), shape);
			wave_count++;
		end

		// registers at the sample limit: no pedestal region ends inside the waveform
		set_config(2048, 2048, 2048);
		queue_waveform(40, SHAPE_PULSE);
		queue_waveform(5, SHAPE_PULSE);

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("waveform_pedestal_integrator_unit_test: PASS");
		end else begin
			$display("waveform_pedestal_integrator_unit_test: FAIL");
		end
		$finish;
	end

endmodule
